FILE: sv/cdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_pkg
// Shared widths, stage types and date arithmetic helpers for the calendar
// date unit.
// ----------------------------------------------------------------------------
package cdu_pkg;

  localparam int unsigned DATE_W     = 27;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned REM_W      = 14;
  localparam int unsigned MON7_W     = 7;
  localparam int unsigned CENT_W     = 8;
  localparam int unsigned MON_W      = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned SUM_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned STAGES     = 6;

  localparam logic [YEAR_W-1:0] YEAR_LO       = YEAR_W'(1000);
  localparam logic [YEAR_W-1:0] YEAR_HI       = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0] MIN_YEAR_RST  = YEAR_W'(2007);
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST  = YEAR_W'(9999);
  localparam logic [DATE_W-1:0] DATE_LO       = DATE_W'(10000000);
  localparam logic [DATE_W-1:0] DATE_HI       = DATE_W'(99999999);
  // (x >> 4) * DIV625_M >> 33 == x / 10000 for any 27-bit x
  localparam logic [23:0]       DIV625_M      = 24'd13743896;
  // (x >> 2) * DIV25_M >> 17 == x / 100 for any 14-bit x
  localparam logic [12:0]       DIV25_M       = 13'd5243;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_YEAR = 2'd0,
    CFG_MAX_YEAR = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON7_W-1:0] month;
    logic [REM_W-1:0]  rem;
    logic [CENT_W-1:0] cent;
    logic              cent_zero;
    logic              leap;
    logic              digits_ok;
  } cdu_split_t;

  typedef struct packed {
    logic [DATE_W-1:0] prev_date;
    logic              prev_ok;
    logic [DATE_W-1:0] next_date;
    logic              next_ok;
    logic [2:0]        weekday;
    logic              date_valid;
  } cdu_res_t;

  function automatic logic [CENT_W-1:0] div100(input logic [REM_W-1:0] x);
    logic [24:0] p;
    p = 25'(x[REM_W-1:2]) * 25'(DIV25_M);
    return p[24:17];
  endfunction

  function automatic logic [2:0] mod7(input logic [SUM_W-1:0] x);
    logic [5:0] f1;
    logic [3:0] f2;
    f1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
    return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // 6 * (m + 1) / 10 for shifted months 3..14
  function automatic logic [3:0] month_term(input logic [MON_W-1:0] zm);
    logic [3:0] t;
    case (zm)
      4'd3:    t = 4'd2;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd4;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd7;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd9;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic logic year_ok(input logic [YEAR_W-1:0] y,
                                   input logic [YEAR_W-1:0] lo,
                                   input logic [YEAR_W-1:0] hi);
    return (y >= YEAR_LO) && (y <= YEAR_HI) && (y >= lo) && (y <= hi);
  endfunction

  function automatic logic [DATE_W-1:0] pack_date(input logic [YEAR_W-1:0] y,
                                                  input logic [MON_W-1:0]  m,
                                                  input logic [DAY_W-1:0]  d);
    return DATE_W'(y) * DATE_W'(10000) + DATE_W'(m) * DATE_W'(100) + DATE_W'(d);
  endfunction

endpackage

FILE: sv/cdu_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_split
// Three pipeline stages that take a YYYYMMDD word apart into year, month
// and day remainder, plus century and leap-year flags.
// ----------------------------------------------------------------------------
module cdu_split
  import cdu_pkg::*;
(
  input  logic              clk_i,
  input  logic [DATE_W-1:0] date_i,
  input  logic [2:0]        en_i,
  output cdu_split_t        split_o
);

  logic [DATE_W-1:0] s1_date_q;
  logic [YEAR_W-1:0] s1_year_q, s1_year_d;
  logic              s1_dig_q, s1_dig_d;
  logic [46:0]       prod;

  logic [YEAR_W-1:0] s2_year_q;
  logic [REM_W-1:0]  s2_rem_q, s2_rem_d;
  logic [CENT_W-1:0] s2_cent_q, s2_cent_d;
  logic              s2_dig_q;
  logic [DATE_W-1:0] rem_full;

  cdu_split_t        s3_q, s3_d;
  logic [YEAR_W-1:0] yr_mod;

  // stage 1: year = value / 10000
  always_comb begin
    prod      = 47'(date_i[DATE_W-1:4]) * 47'(DIV625_M);
    s1_year_d = prod[46:33];
    s1_dig_d  = (date_i >= DATE_LO) && (date_i <= DATE_HI);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_date_q <= date_i;
      s1_year_q <= s1_year_d;
      s1_dig_q  <= s1_dig_d;
    end
  end

  // stage 2: low four digits, century
  always_comb begin
    rem_full  = s1_date_q - DATE_W'(s1_year_q) * DATE_W'(10000);
    s2_rem_d  = rem_full[REM_W-1:0];
    s2_cent_d = div100(s1_year_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_year_q <= s1_year_q;
      s2_rem_q  <= s2_rem_d;
      s2_cent_q <= s2_cent_d;
      s2_dig_q  <= s1_dig_q;
    end
  end

  // stage 3: month, leap rule
  always_comb begin
    yr_mod           = s2_year_q - YEAR_W'(s2_cent_q) * YEAR_W'(100);
    s3_d.year        = s2_year_q;
    s3_d.month       = MON7_W'(div100(s2_rem_q));
    s3_d.rem         = s2_rem_q;
    s3_d.cent        = s2_cent_q;
    s3_d.cent_zero   = (yr_mod == '0);
    s3_d.leap        = ((s2_year_q[1:0] == 2'b00) && (yr_mod != '0)) ||
                       ((yr_mod == '0) && (s2_cent_q[1:0] == 2'b00));
    s3_d.digits_ok   = s2_dig_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_q <= s3_d;
    end
  end

  assign split_o = s3_q;

endmodule

FILE: sv/cdu_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_calc
// Date check, weekday sum and neighbour dates, then weekday reduction and
// packing into the result register.
// ----------------------------------------------------------------------------
module cdu_calc
  import cdu_pkg::*;
(
  input  logic              clk_i,
  input  cdu_split_t        split_i,
  input  logic [YEAR_W-1:0] min_year_i,
  input  logic [YEAR_W-1:0] max_year_i,
  input  logic [1:0]        en_i,
  output cdu_res_t          res_o
);

  logic [REM_W-1:0]  day_full;
  logic [6:0]        day;
  logic [MON_W-1:0]  mon;
  logic [DAY_W-1:0]  mlen;
  logic              mon_ok, day_ok, valid_d;
  logic              jf, at_end, at_start;
  logic [MON_W-1:0]  zm;
  logic [YEAR_W-1:0] zy;
  logic [CENT_W-1:0] zc;
  logic [SUM_W-1:0]  sum_d;
  logic [YEAR_W-1:0] ny, py;
  logic [MON_W-1:0]  nm, pm;
  logic [DAY_W-1:0]  nd, pd;

  logic              valid_q, nok_q, pok_q;
  logic [SUM_W-1:0]  sum_q;
  logic [YEAR_W-1:0] ny_q, py_q;
  logic [MON_W-1:0]  nm_q, pm_q;
  logic [DAY_W-1:0]  nd_q, pd_q;

  cdu_res_t          res_q, res_d;

  always_comb begin
    day_full = split_i.rem - REM_W'(split_i.month) * REM_W'(100);
    day      = day_full[6:0];
    mon      = split_i.month[MON_W-1:0];
    mlen     = month_len(split_i.leap, mon);
    mon_ok   = split_i.month inside {[7'd1:7'd12]};
    day_ok   = (day >= 7'd1) && (day <= 7'(mlen));
    valid_d  = split_i.digits_ok && mon_ok && day_ok &&
               year_ok(split_i.year, min_year_i, max_year_i);

    // Jan/Feb count as months 13/14 of the year before
    jf    = (mon < 4'd3);
    zm    = jf ? mon + 4'd12 : mon;
    zy    = split_i.year - YEAR_W'(jf);
    zc    = split_i.cent - CENT_W'(jf && split_i.cent_zero);
    sum_d = SUM_W'(day) + SUM_W'({zm, 1'b0}) + SUM_W'(month_term(zm)) +
            SUM_W'(zy) + SUM_W'(zy[YEAR_W-1:2]) - SUM_W'(zc) +
            SUM_W'(zc[CENT_W-1:2]) + SUM_W'(1);

    at_end = (DAY_W'(day) == mlen);
    nd     = at_end ? 5'd1 : DAY_W'(day) + 5'd1;
    nm     = at_end ? ((mon == 4'd12) ? 4'd1 : mon + 4'd1) : mon;
    ny     = (at_end && (mon == 4'd12)) ? split_i.year + YEAR_W'(1) : split_i.year;

    at_start = (day == 7'd1);
    pm       = at_start ? ((mon == 4'd1) ? 4'd12 : mon - 4'd1) : mon;
    py       = (at_start && (mon == 4'd1)) ? split_i.year - YEAR_W'(1) : split_i.year;
    pd       = at_start ? month_len(split_i.leap, pm) : DAY_W'(day) - 5'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      valid_q <= valid_d;
      sum_q   <= sum_d;
      nok_q   <= valid_d && year_ok(ny, min_year_i, max_year_i);
      ny_q    <= ny;
      nm_q    <= nm;
      nd_q    <= nd;
      pok_q   <= valid_d && year_ok(py, min_year_i, max_year_i);
      py_q    <= py;
      pm_q    <= pm;
      pd_q    <= pd;
    end
  end

  always_comb begin
    res_d.date_valid = valid_q;
    res_d.weekday    = valid_q ? mod7(sum_q) : 3'd0;
    res_d.next_ok    = nok_q;
    res_d.next_date  = nok_q ? pack_date(ny_q, nm_q, nd_q) : '0;
    res_d.prev_ok    = pok_q;
    res_d.prev_date  = pok_q ? pack_date(py_q, pm_q, pd_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: sv/calendar_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_unit
// Gregorian YYYYMMDD check with weekday and next/previous date.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------
//   s_axis   | in  | tvalid / tready      | tdata: date_value
//   m_axis   | out | tvalid / tready      | tdata: result word
//   cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (year)
//
// One word per cycle sustained while m_axis_tready is high; each word passes
// through the six-stage register chain (input reg, three split stages, check, result).
// Reset sets min_year 2007, max_year 9999 and empties the pipeline.
// Stages advance into empty slots; a stalled output only stops input once
// all six stages hold words. cfg_ready is always high.
// ----------------------------------------------------------------------------
module calendar_date_unit
  import cdu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [26:0] date_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] date_valid, [3:1] weekday,
                                                 // [4] next_ok, [31:5] next_date,
                                                 // [32] prev_ok, [59:33] prev_date
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [YEAR_W-1:0]      cfg_data_i
);

  logic [YEAR_W-1:0] min_year_q, max_year_q;
  logic [STAGES-1:0] vld_q, vld_d, en;
  logic [DATE_W-1:0] date_q;
  cdu_split_t        split;
  cdu_res_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RST;
      max_year_q <= MAX_YEAR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_YEAR: min_year_q <= cfg_data_i;
        CFG_MAX_YEAR: max_year_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || m_axis_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int i = 1; i < STAGES; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      date_q <= s_axis_tdata[DATE_W-1:0];
    end
  end

  cdu_split u_split (
    .clk_i   (clk_i),
    .date_i  (date_q),
    .en_i    (en[3:1]),
    .split_o (split)
  );

  cdu_calc u_calc (
    .clk_i      (clk_i),
    .split_i    (split),
    .min_year_i (min_year_q),
    .max_year_i (max_year_q),
    .en_i       (en[5:4]),
    .res_o      (res)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[STAGES-1];
  assign m_axis_tdata  = OUT_TDATA_W'(res);

endmodule

FILE: sv/cdu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_checker
// Port-level checks for the calendar date unit, bound to the top level.
// ----------------------------------------------------------------------------
module cdu_checker
  import cdu_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // an empty output stage means the pipe has room
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // invalid date gives an all-zero word
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[63:1] == '0))
    else $error("invalid date with nonzero fields");

  // neighbour flags need a valid date, dates are zero without their flag
  a_neighbors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (!(m_axis_tdata[4] || m_axis_tdata[32]) || m_axis_tdata[0]) &&
      (m_axis_tdata[4] || (m_axis_tdata[31:5] == '0)) &&
      (m_axis_tdata[32] || (m_axis_tdata[59:33] == '0)) &&
      (m_axis_tdata[3:1] != 3'd7))
    else $error("neighbour fields inconsistent");

endmodule

bind calendar_date_unit cdu_checker u_cdu_checker (.*);
